/* hdl/chisq_pkg.sv */
// ============================================================================
// chisq_pkg
// Shared widths, register indexes and reset values for the chi-square core.
// ============================================================================
package chisq_pkg;

    // Field widths
    localparam int OBS_W    = 20;               // observed count
    localparam int SAMPLE_W = 20;               // sample size
    localparam int PROB_W   = 16;               // Q0.16 probability
    localparam int CRIT_W   = 32;               // Q16.16 critical level
    localparam int STAT_W   = 40;               // Q24.16 statistic
    localparam int FRAC_W   = 16;               // fraction bits of counts
    localparam int EXP_W    = 36;               // Q20.16 expected count
    localparam int HALF_W   = EXP_W / 2;        // half of a difference word
    localparam int MUL_W    = 20;               // shared multiplier operand
    localparam int PROD_W   = 2 * MUL_W;        // shared multiplier product
    localparam int SQ_W     = 2 * EXP_W;        // squared difference

    // Number of probability registers and default category count
    localparam int NUM_PROBS            = 5;
    localparam int NUM_CATEGORIES_DEF   = 5;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_SIZE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PROB_ALL_DIFF  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PROB_ONE_PAIR  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PROB_TWO_PAIR  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PROB_THREE     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PROB_ALL_SAME  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CRITICAL_LEVEL = 3'd6;

    // Reset values
    localparam logic [SAMPLE_W-1:0] RST_SAMPLE_SIZE = 20'd1000;
    localparam logic [PROB_W-1:0]   RST_PROB_ALL_DIFF = 16'd33030;
    localparam logic [PROB_W-1:0]   RST_PROB_ONE_PAIR = 16'd28312;
    localparam logic [PROB_W-1:0]   RST_PROB_TWO_PAIR = 16'd1769;
    localparam logic [PROB_W-1:0]   RST_PROB_THREE    = 16'd2359;
    localparam logic [PROB_W-1:0]   RST_PROB_ALL_SAME = 16'd66;
    localparam logic [CRIT_W-1:0]   RST_CRITICAL      = 32'd621806;

    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

    // Live configuration handed from the register file to the datapath
    typedef struct packed {
        logic [SAMPLE_W-1:0]                 sample_size;
        logic [NUM_PROBS-1:0][PROB_W-1:0]    prob;
        logic [CRIT_W-1:0]                   critical_level;
    } t_cfg;

    // Divider handshake from the sequencer
    typedef struct packed {
        logic              start;
        logic [SQ_W-1:0]   dividend;
        logic [EXP_W-1:0]  divisor;
    } t_div_req;

endpackage

/* hdl/chi_square_goodness_of_fit_core.sv */
// ============================================================================
// chi_square_goodness_of_fit_core
// Pearson chi-square goodness-of-fit accumulator over a fixed set of counts.
// ============================================================================
// Each observed-count beat occupies the core, with the input stalled
// meanwhile: the accept, the expected-count multiply, squaring in states
// ST_SQ1 to ST_SQ4, the divider handoff, the 72-step restoring divider and
// the add of the term. After the last category ST_OUT loads the result once
// the result register has room, and the result beat is then valid.
// Reset (i_rst_n low at a clock edge) loads defaults and clears index, sum, output.
// ============================================================================
module chi_square_goodness_of_fit_core
    import chisq_pkg::*;
#(
    parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Observed-count channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OBS_W-1:0]        i_observed_count,
    // Result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [STAT_W-1:0]       o_statistic,
    output logic                    o_reject,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int IDX_W = $clog2(NUM_CATEGORIES);
    localparam int ST_W  = 4;

    // Sequencer states. Each beat walks through the expected-count multiply,
    // three partial products of the squared difference, then the divider.
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_EXP   = 4'd1;
    localparam logic [ST_W-1:0] ST_SQ1   = 4'd2;
    localparam logic [ST_W-1:0] ST_SQ2   = 4'd3;
    localparam logic [ST_W-1:0] ST_SQ3   = 4'd4;
    localparam logic [ST_W-1:0] ST_SQ4   = 4'd5;
    localparam logic [ST_W-1:0] ST_DIVGO = 4'd6;
    localparam logic [ST_W-1:0] ST_DIVW  = 4'd7;
    localparam logic [ST_W-1:0] ST_OUT   = 4'd8;

    t_cfg                   w_cfg;
    t_div_req               w_div_req;
    logic                   w_div_done;
    logic [STAT_W-1:0]      w_quot;

    logic [ST_W-1:0]        r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [STAT_W-1:0]      r_sum, n_sum;
    logic [OBS_W-1:0]       r_obs;
    logic [EXP_W-1:0]       r_exp;
    logic [EXP_W-1:0]       r_d;
    logic [SQ_W-1:0]        r_sq;
    logic                   r_out_valid, n_out_valid;
    logic [STAT_W-1:0]      r_statistic;
    logic                   r_reject;

    logic [MUL_W-1:0]       w_mul_a, w_mul_b;
    logic [PROD_W-1:0]      w_prod;
    logic [PROB_W-1:0]      w_prob;
    logic [EXP_W-1:0]       w_obs_q;
    logic [EXP_W-1:0]       w_exp_new;
    logic [EXP_W-1:0]       w_diff;
    logic [HALF_W-1:0]      w_d_hi, w_d_lo;
    logic [STAT_W:0]        w_sum_wide;
    logic [STAT_W-1:0]      w_sum_sat;
    logic                   w_last;
    logic                   w_accept;
    logic                   w_out_free;

    chisq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    chisq_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    chisq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_last     = (r_idx == IDX_W'(NUM_CATEGORIES - 1));
    assign w_out_free = !r_out_valid || !i_stall;

    // Categories beyond the probability registers behave as probability zero,
    // which drives the expected count to zero and saturates the statistic.
    always_comb begin
        w_prob = '0;
        for (int k = 0; k < NUM_PROBS; k++) begin
            if (int'(r_idx) == k) begin
                w_prob = w_cfg.prob[k];
            end
        end
    end

    // The expected count is the product of probability and sample size, held
    // in Q20.16. The observed count shares that scale after a 16-bit shift.
    assign w_obs_q   = {r_obs, {FRAC_W{1'b0}}};
    assign w_exp_new = w_prod[EXP_W-1:0];
    assign w_diff    = (w_obs_q >= w_exp_new) ? (w_obs_q - w_exp_new)
                                              : (w_exp_new - w_obs_q);
    assign w_d_hi    = r_d[EXP_W-1:HALF_W];
    assign w_d_lo    = r_d[HALF_W-1:0];

    // Shared multiplier operand select. The squared difference is built from
    // hi*hi, hi*lo (counted twice by a one-bit-larger shift) and lo*lo.
    always_comb begin
        case (r_state)
            ST_IDLE: begin
                w_mul_a = MUL_W'(w_prob);
                w_mul_b = MUL_W'(w_cfg.sample_size);
            end
            ST_SQ1: begin
                w_mul_a = MUL_W'(w_d_hi);
                w_mul_b = MUL_W'(w_d_hi);
            end
            ST_SQ2: begin
                w_mul_a = MUL_W'(w_d_hi);
                w_mul_b = MUL_W'(w_d_lo);
            end
            ST_SQ3: begin
                w_mul_a = MUL_W'(w_d_lo);
                w_mul_b = MUL_W'(w_d_lo);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_div_req.start    = (r_state == ST_DIVGO);
    assign w_div_req.dividend = r_sq;
    assign w_div_req.divisor  = r_exp;

    // Saturating accumulation of the finished term.
    assign w_sum_wide = {1'b0, r_sum} + {1'b0, w_quot};
    assign w_sum_sat  = w_sum_wide[STAT_W] ? STAT_MAX : w_sum_wide[STAT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXP;
                end
            end
            ST_EXP:   n_state = ST_SQ1;
            ST_SQ1:   n_state = ST_SQ2;
            ST_SQ2:   n_state = ST_SQ3;
            ST_SQ3:   n_state = ST_SQ4;
            ST_SQ4:   n_state = ST_DIVGO;
            ST_DIVGO: n_state = ST_DIVW;
            ST_DIVW: begin
                if (w_div_done) begin
                    n_sum = w_sum_sat;
                    if (w_last) begin
                        n_state = ST_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                // Wait for room in the result register, then start a new test.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_idx       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_obs <= i_observed_count;
        end
        case (r_state)
            ST_EXP: begin
                r_exp <= w_exp_new;
                r_d   <= w_diff;
            end
            ST_SQ2: r_sq <= {w_prod[EXP_W-1:0], {EXP_W{1'b0}}};
            ST_SQ3: r_sq <= r_sq + (SQ_W'(w_prod) << (HALF_W + 1));
            ST_SQ4: r_sq <= r_sq + SQ_W'(w_prod);
            default: begin
            end
        endcase
        if (r_state == ST_OUT && w_out_free) begin
            r_statistic <= r_sum;
            r_reject    <= (r_sum > STAT_W'(w_cfg.critical_level));
        end
    end

    assign o_valid     = r_out_valid;
    assign o_statistic = r_statistic;
    assign o_reject    = r_reject;

endmodule

/* hdl/chisq_regs.sv */
// ============================================================================
// chisq_regs
// Configuration register file behind a simple APB-style slave port.
// ============================================================================
module chisq_regs
    import chisq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg                  r_cfg;
    logic [REG_IDX_W-1:0]  w_idx;
    logic                  w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_size    <= RST_SAMPLE_SIZE;
            r_cfg.prob[0]        <= RST_PROB_ALL_DIFF;
            r_cfg.prob[1]        <= RST_PROB_ONE_PAIR;
            r_cfg.prob[2]        <= RST_PROB_TWO_PAIR;
            r_cfg.prob[3]        <= RST_PROB_THREE;
            r_cfg.prob[4]        <= RST_PROB_ALL_SAME;
            r_cfg.critical_level <= RST_CRITICAL;
        end else if (w_wr) begin
            case (w_idx)
                REG_SAMPLE_SIZE:    r_cfg.sample_size    <= pwdata[SAMPLE_W-1:0];
                REG_PROB_ALL_DIFF:  r_cfg.prob[0]        <= pwdata[PROB_W-1:0];
                REG_PROB_ONE_PAIR:  r_cfg.prob[1]        <= pwdata[PROB_W-1:0];
                REG_PROB_TWO_PAIR:  r_cfg.prob[2]        <= pwdata[PROB_W-1:0];
                REG_PROB_THREE:     r_cfg.prob[3]        <= pwdata[PROB_W-1:0];
                REG_PROB_ALL_SAME:  r_cfg.prob[4]        <= pwdata[PROB_W-1:0];
                REG_CRITICAL_LEVEL: r_cfg.critical_level <= pwdata[CRIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SAMPLE_SIZE:    prdata = APB_DATA_W'(r_cfg.sample_size);
            REG_PROB_ALL_DIFF:  prdata = APB_DATA_W'(r_cfg.prob[0]);
            REG_PROB_ONE_PAIR:  prdata = APB_DATA_W'(r_cfg.prob[1]);
            REG_PROB_TWO_PAIR:  prdata = APB_DATA_W'(r_cfg.prob[2]);
            REG_PROB_THREE:     prdata = APB_DATA_W'(r_cfg.prob[3]);
            REG_PROB_ALL_SAME:  prdata = APB_DATA_W'(r_cfg.prob[4]);
            REG_CRITICAL_LEVEL: prdata = APB_DATA_W'(r_cfg.critical_level);
            default:            prdata = '0;
        endcase
    end

endmodule

/* hdl/chisq_mul.sv */
// ============================================================================
// chisq_mul
// Shared unsigned multiplier with a registered product.
// ============================================================================
module chisq_mul
    import chisq_pkg::*;
(
    input  logic                i_clk,
    input  logic [MUL_W-1:0]    i_a,
    input  logic [MUL_W-1:0]    i_b,
    output logic [PROD_W-1:0]   o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hdl/chisq_div.sv */
// ============================================================================
// chisq_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ============================================================================
module chisq_div
    import chisq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [STAT_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(SQ_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SQ_W-1:0]     r_num;
    logic [EXP_W-1:0]    r_div;
    logic [EXP_W-1:0]    r_rem;
    logic [STAT_W-1:0]   r_q;
    logic                r_ovf;

    logic [EXP_W:0]      w_rem_sh;
    logic [EXP_W:0]      w_rem_sub;
    logic                w_ge;

    // Bring down the next dividend bit and try the subtraction.
    assign w_rem_sh  = {r_rem, r_num[SQ_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_q   <= '0;
            // A zero divisor saturates the quotient outright.
            r_ovf <= (i_req.divisor == '0);
        end else if (r_busy) begin
            r_num <= {r_num[SQ_W-2:0], 1'b0};
            r_rem <= w_ge ? w_rem_sub[EXP_W-1:0] : w_rem_sh[EXP_W-1:0];
            r_q   <= {r_q[STAT_W-2:0], w_ge};
            r_ovf <= r_ovf | r_q[STAT_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_ovf ? STAT_MAX : r_q;

endmodule
